>>> rtl/utf8_to_code_point_decoder_assert.svh
// Assertion macros shared by the UTF-8 decoder RTL.
`ifndef UTF8_TO_CODE_POINT_DECODER_ASSERT_SVH
`define UTF8_TO_CODE_POINT_DECODER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset; uses the module's clk and rst_n.
`define UTF8_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("UTF-8 decoder assertion failed");
// Checked at every clock edge, reset included.
`define UTF8_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("UTF-8 decoder assertion failed");
`else
`define UTF8_ASSERT(lbl, prop)
`define UTF8_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> rtl/utf8dec_pkg.sv
// Types and constants shared by the UTF-8 decoder modules.
`default_nettype none
package utf8dec_pkg;

  localparam int unsigned CpW = 21;

  typedef logic [1:0] status_t;
  localparam status_t ST_CODE       = 2'd0;
  localparam status_t ST_ILLEGAL    = 2'd1;
  localparam status_t ST_INCOMPLETE = 2'd2;
  localparam status_t ST_END        = 2'd3;

  localparam logic [CpW-1:0] CP_REPLACEMENT = 21'h00FFFD;
  localparam logic [CpW-1:0] CP_MAX_SCALAR  = 21'h10FFFF;
  localparam logic [CpW-1:0] CP_SURR_LO     = 21'h00D800;
  localparam logic [CpW-1:0] CP_SURR_HI     = 21'h00DFFF;

  typedef struct packed {
    logic [CpW-1:0] partial;
    logic [1:0]     remaining;
    logic [2:0]     seq_len;
    logic [7:0]     lead;
    logic [2:0]     seen;
  } dec_state_t;

  typedef struct packed {
    logic [CpW-1:0] code_point;
    status_t        status;
    logic [2:0]     seq_bytes;
  } dec_result_t;

endpackage
`default_nettype wire

>>> rtl/utf8dec_step.sv
// Next-state and result logic for one byte or end word of the decoder.
`default_nettype none
module utf8dec_step (
  input  utf8dec_pkg::dec_state_t  state,
  input  logic [7:0]               data_byte,
  input  logic                     end_marker,
  output utf8dec_pkg::dec_state_t  state_nxt,
  output logic                     res_valid,
  output utf8dec_pkg::dec_result_t res
);
  import utf8dec_pkg::*;

  logic [7:0]     lo;
  logic [7:0]     hi;
  logic [CpW-1:0] acc;
  logic [1:0]     rem_dec;

  always_comb begin
    lo = 8'h80;
    hi = 8'hBF;
    if (state.seen == 3'd1) begin
      case (state.lead)
        8'hE0:   lo = 8'hA0;
        8'hED:   hi = 8'h9F;
        8'hF0:   lo = 8'h90;
        8'hF4:   hi = 8'h8F;
        default: ;
      endcase
    end
  end

  assign acc     = {state.partial[CpW-7:0], data_byte[5:0]};
  assign rem_dec = state.remaining - 2'd1;

  always_comb begin
    state_nxt = state;
    res_valid = 1'b0;
    res       = '0;
    if (end_marker) begin
      res_valid = 1'b1;
      if (state.remaining != 2'd0) begin
        res.status    = ST_INCOMPLETE;
        res.seq_bytes = state.seen;
      end else begin
        res.status = ST_END;
      end
    end else if (state.remaining == 2'd0) begin
      if (data_byte < 8'h80) begin
        res_valid       = 1'b1;
        res.code_point  = {{(CpW-8){1'b0}}, data_byte};
        res.status      = ST_CODE;
        res.seq_bytes   = 3'd1;
      end else if (data_byte < 8'hC2 || data_byte > 8'hF4) begin
        res_valid     = 1'b1;
        res.status    = ST_ILLEGAL;
        res.seq_bytes = 3'd1;
      end else begin
        // Lead byte of a multi-byte sequence: keep its payload bits.
        if (data_byte < 8'hE0) begin
          state_nxt.seq_len = 3'd2;
          state_nxt.partial = {{(CpW-5){1'b0}}, data_byte[4:0]};
        end else if (data_byte < 8'hF0) begin
          state_nxt.seq_len = 3'd3;
          state_nxt.partial = {{(CpW-4){1'b0}}, data_byte[3:0]};
        end else begin
          state_nxt.seq_len = 3'd4;
          state_nxt.partial = {{(CpW-3){1'b0}}, data_byte[2:0]};
        end
        state_nxt.remaining = state_nxt.seq_len[1:0] - 2'd1;
        state_nxt.lead      = data_byte;
        state_nxt.seen      = 3'd1;
      end
    end else if (data_byte < lo || data_byte > hi) begin
      // Bad continuation byte drops the sequence together with itself.
      res_valid     = 1'b1;
      res.status    = ST_ILLEGAL;
      res.seq_bytes = state.seen + 3'd1;
      state_nxt     = '0;
    end else if (rem_dec == 2'd0) begin
      res_valid     = 1'b1;
      res.status    = ST_CODE;
      res.seq_bytes = state.seq_len;
      if (acc > CP_MAX_SCALAR || (acc >= CP_SURR_LO && acc <= CP_SURR_HI)) begin
        res.code_point = CP_REPLACEMENT;
      end else begin
        res.code_point = acc;
      end
      state_nxt = '0;
    end else begin
      state_nxt.partial   = acc;
      state_nxt.seen      = state.seen + 3'd1;
      state_nxt.remaining = rem_dec;
    end
  end

endmodule
`default_nettype wire

>>> rtl/utf8dec_out_buf.sv
// Output register stage that holds one result word for the stream.
`default_nettype none
module utf8dec_out_buf (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     load,
  input  utf8dec_pkg::dec_result_t res,
  output logic                     can_load,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  output utf8dec_pkg::dec_result_t out_res
);
  import utf8dec_pkg::*;

  logic        valid_r;
  logic        valid_nxt;
  dec_result_t res_r;

  assign can_load  = !valid_r || out_tready;
  assign valid_nxt = load || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule
`default_nettype wire

>>> rtl/utf8_to_code_point_decoder.sv
// Top level of the UTF-8 to code point decoder.
// Path: an accepted input word passes through the input register, then through the
// decode logic into the output register, which presents the result word.
// Throughput: one input word per cycle while the output register can take a result.
// Reset: synchronous active-low rst_n empties both registers and returns the
// decoder to idle with no sequence pending.
`default_nettype none
`include "utf8_to_code_point_decoder_assert.svh"
module utf8_to_code_point_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_marker: end of buffer, no byte carried
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [20:0] code_point, [23:21] sequence_bytes
  output logic [1:0]  out_tuser   // [1:0] status
);
  import utf8dec_pkg::*;

  // Input register: holds one accepted word until the decode stage takes it.
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_end_r;

  // Decoder sequence state; idle whenever remaining is zero.
  dec_state_t  state_r;
  dec_state_t  state_nxt;

  logic        res_valid;
  dec_result_t res;
  dec_result_t out_res;
  logic        buf_can_load;
  logic        advance;

  // The decode stage moves whenever it holds a word and the output register
  // can take a result this cycle; a word that produces no result also waits
  // for the output register while it is full and stalled.
  assign advance   = in_valid_r && buf_can_load;
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      state_r    <= '0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (advance) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  utf8dec_step u_step (
    .state      (state_r),
    .data_byte  (in_byte_r),
    .end_marker (in_end_r),
    .state_nxt  (state_nxt),
    .res_valid  (res_valid),
    .res        (res)
  );

  utf8dec_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && res_valid),
    .res        (res),
    .can_load   (buf_can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.seq_bytes, out_res.code_point};
  assign out_tuser = out_res.status;

  // An idle decoder carries no leftover sequence bookkeeping.
  `UTF8_ASSERT_ALWAYS(a_idle_clean,
    (state_r.remaining == 2'd0) |-> (state_r.seen == 3'd0 && state_r.seq_len == 3'd0))
  // Bytes seen plus bytes still expected always add up to the sequence length.
  `UTF8_ASSERT(a_count_sum,
    (state_r.remaining != 2'd0) |->
      (state_r.seen + {1'b0, state_r.remaining} == state_r.seq_len))
  // A decoded code point comes from one to four bytes and is never a surrogate.
  `UTF8_ASSERT(a_code_ok,
    (out_tvalid && out_tuser == ST_CODE) |->
      (out_tdata[23:21] != 3'd0 && out_tdata[23:21] <= 3'd4 &&
       !(out_tdata[20:0] >= CP_SURR_LO && out_tdata[20:0] <= CP_SURR_HI)))
  // Status words other than a code point carry a zero code point.
  `UTF8_ASSERT(a_status_zero_cp,
    (out_tvalid && out_tuser != ST_CODE) |-> (out_tdata[20:0] == '0))

endmodule
`default_nettype wire
